>>> rtl/rfr_pkg.sv
// Package for the radio frame receiver: widths, header codes, parser states,
// status codes and the structs shared by the parser, output stage and top level.
// No dependencies.
`default_nettype none
package rfr_pkg;

  localparam int BUFFER_BYTES   = 512;
  localparam int WAYPOINT_BYTES = 16;

  localparam int CFG_W   = 10;
  localparam int COUNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int LEN_W   = 16;
  localparam int SUM_W   = 16;
  localparam int WPC_W   = 10;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;

  localparam logic [CFG_W-1:0] CMD_LENGTH_RESET = CFG_W'(76);
  localparam logic [CFG_W-1:0] WP_OFFSET_RESET  = CFG_W'(12);

  localparam logic [LEN_W-1:0] MIN_FRAME_LEN = LEN_W'(4);
  localparam logic [LEN_W-1:0] MAX_FRAME_LEN = LEN_W'(BUFFER_BYTES);

  typedef enum logic [0:0] {
    REG_CMD_LENGTH = 1'b0,
    REG_WP_OFFSET  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_HUNT1 = 2'd0,
    PH_HUNT2 = 2'd1,
    PH_LEN   = 2'd2,
    PH_DATA  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_CMD_OK   = 2'd0,
    ST_CMD_BAD  = 2'd1,
    ST_WAYPOINT = 2'd2,
    ST_REJECT   = 2'd3
  } status_t;

  typedef struct packed {
    logic [CFG_W-1:0] cmd_length;
    logic [CFG_W-1:0] wp_offset;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] frame_length;
    logic [WPC_W-1:0] waypoint_count;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/radio_frame_receiver_unit.sv
// Top level of the radio frame receiver: input word register, configuration
// registers, frame parser and result register. Depends on rfr_pkg, rfr_parser, rfr_out_stage.
//
// Each received byte is one input word. The receiver hunts for the header 0xAA 0x55,
// takes a little-endian 16-bit total frame length and reports one status word per
// frame (command ok, command checksum bad, waypoint frame, or length rejected).
// It takes one byte per clock cycle at full rate while the result register can take a
// word; a byte passes through an input register to the parser, and a frame's status word
// is loaded into the result register when the parser takes the byte that ends the frame.
// The rate is set by the parser state update. Configuration writes are accepted at any
// time with cfg_ready held high and must be made while no frame is in progress.
`default_nettype none
module radio_frame_receiver_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] frame_length, [25:16] waypoint_count, rest zero
  output logic [1:0]       out_tuser,  // [1:0] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);
  import rfr_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       step;
  logic       can_load;
  logic       emit;
  result_t    result;
  result_t    out_result;
  cfg_t       cfg_r;

  assign step         = in_valid_r && can_load;
  assign in_tready    = !in_valid_r || step;
  assign in_valid_nxt = (in_tvalid && in_tready) || (in_valid_r && !step);
  assign cfg_ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cmd_length <= CMD_LENGTH_RESET;
      cfg_r.wp_offset  <= WP_OFFSET_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CMD_LENGTH: cfg_r.cmd_length <= cfg_data;
        REG_WP_OFFSET:  cfg_r.wp_offset  <= cfg_data;
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  rfr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .cfg     (cfg_r),
    .emit    (emit),
    .result  (result)
  );

  rfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step && emit),
    .result     (result),
    .can_load   (can_load),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {6'b0, out_result.waypoint_count, out_result.frame_length};
  assign out_tuser = out_result.status;

endmodule
`default_nettype wire

>>> rtl/rfr_parser.sv
// Frame parser: header hunt, length capture, byte count, running sum and the
// end-of-frame classification. Depends on rfr_pkg.
`default_nettype none
module rfr_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire logic [7:0]      rx_byte,
  input  wire rfr_pkg::cfg_t   cfg,
  output logic                 emit,
  output rfr_pkg::result_t     result
);
  import rfr_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [7:0]         length_low_r, length_low_nxt;
  logic               length_step_r, length_step_nxt;
  logic [LEN_W-1:0]   total_length_r, total_length_nxt;
  logic [COUNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [SUM_W-1:0]   running_sum_r, running_sum_nxt;
  logic [7:0]         prev_byte_r, prev_byte_nxt;

  logic [COUNT_W-1:0] count_inc;
  logic [SUM_W-1:0]   sum_inc;
  logic [LEN_W-1:0]   len_word;
  logic [LEN_W-1:0]   cmd_len_ext;
  logic [LEN_W-1:0]   wp_off_ext;
  logic               len_bad;
  logic               is_cmd;
  logic [SUM_W-1:0]   check_sum;
  logic [LEN_W-1:0]   wp_bytes;
  status_t            finish_status;
  logic [WPC_W-1:0]   finish_count;

  assign count_inc   = byte_count_r + COUNT_W'(1);
  assign sum_inc     = running_sum_r + SUM_W'(rx_byte);
  assign cmd_len_ext = LEN_W'(cfg.cmd_length);
  assign wp_off_ext  = LEN_W'(cfg.wp_offset);

  // In the data phase the length is settled; on the second length byte it comes from the wire.
  always_comb begin
    if (phase_r == PH_LEN) begin
      len_word = {rx_byte, length_low_r};
    end else begin
      len_word = total_length_r;
    end
  end

  assign len_bad = (len_word < MIN_FRAME_LEN) || (len_word > MAX_FRAME_LEN) ||
                   ((len_word != cmd_len_ext) && (len_word < wp_off_ext));
  assign is_cmd  = (len_word == cmd_len_ext);

  // The last two bytes are the previous byte and this one; leave them out of the sum.
  assign check_sum = running_sum_r - SUM_W'(prev_byte_r);
  assign wp_bytes  = len_word - wp_off_ext;

  always_comb begin
    if (is_cmd) begin
      finish_count = '0;
      if (check_sum == {rx_byte, prev_byte_r}) begin
        finish_status = ST_CMD_OK;
      end else begin
        finish_status = ST_CMD_BAD;
      end
    end else begin
      finish_status = ST_WAYPOINT;
      finish_count  = WPC_W'(wp_bytes / WAYPOINT_BYTES);
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    length_low_nxt   = length_low_r;
    length_step_nxt  = length_step_r;
    total_length_nxt = total_length_r;
    byte_count_nxt   = byte_count_r;
    running_sum_nxt  = running_sum_r;
    prev_byte_nxt    = prev_byte_r;
    case (phase_r)
      PH_HUNT2: begin
        if (rx_byte == HDR_SECOND) begin
          byte_count_nxt  = count_inc;
          running_sum_nxt = sum_inc;
          prev_byte_nxt   = rx_byte;
          length_step_nxt = 1'b0;
          phase_nxt       = PH_LEN;
        end else begin
          byte_count_nxt  = '0;
          running_sum_nxt = '0;
          phase_nxt       = PH_HUNT1;
        end
      end
      PH_LEN: begin
        byte_count_nxt  = count_inc;
        running_sum_nxt = sum_inc;
        prev_byte_nxt   = rx_byte;
        if (!length_step_r) begin
          length_low_nxt  = rx_byte;
          length_step_nxt = 1'b1;
        end else begin
          length_step_nxt  = 1'b0;
          total_length_nxt = len_word;
          if (len_bad) begin
            phase_nxt = PH_HUNT1;
          end else if (LEN_W'(count_inc) >= len_word) begin
            phase_nxt = PH_HUNT1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        byte_count_nxt  = count_inc;
        running_sum_nxt = sum_inc;
        prev_byte_nxt   = rx_byte;
        if (LEN_W'(count_inc) >= len_word) begin
          phase_nxt = PH_HUNT1;
        end
      end
      default: begin
        if (rx_byte == HDR_FIRST) begin
          byte_count_nxt  = COUNT_W'(1);
          running_sum_nxt = SUM_W'(rx_byte);
          prev_byte_nxt   = rx_byte;
          phase_nxt       = PH_HUNT2;
        end
      end
    endcase
  end

  always_comb begin
    emit                  = 1'b0;
    result.status         = ST_REJECT;
    result.frame_length   = len_word;
    result.waypoint_count = '0;
    case (phase_r)
      PH_LEN: begin
        if (length_step_r) begin
          if (len_bad) begin
            emit = 1'b1;
          end else if (LEN_W'(count_inc) >= len_word) begin
            emit                  = 1'b1;
            result.status         = finish_status;
            result.waypoint_count = finish_count;
          end
        end
      end
      PH_DATA: begin
        if (LEN_W'(count_inc) >= len_word) begin
          emit                  = 1'b1;
          result.status         = finish_status;
          result.waypoint_count = finish_count;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT1;
      length_low_r   <= '0;
      length_step_r  <= 1'b0;
      total_length_r <= '0;
      byte_count_r   <= '0;
      running_sum_r  <= '0;
      prev_byte_r    <= '0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      length_low_r   <= length_low_nxt;
      length_step_r  <= length_step_nxt;
      total_length_r <= total_length_nxt;
      byte_count_r   <= byte_count_nxt;
      running_sum_r  <= running_sum_nxt;
      prev_byte_r    <= prev_byte_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rfr_out_stage.sv
// Result register of the frame receiver: holds one status word until the
// downstream side takes it. Depends on rfr_pkg.
`default_nettype none
module rfr_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire rfr_pkg::result_t result,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output rfr_pkg::result_t      out_result
);
  import rfr_pkg::*;

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign can_load   = !valid_r || out_ready;
  assign valid_nxt  = load || (valid_r && !out_ready);
  assign out_valid  = valid_r;
  assign out_result = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule
`default_nettype wire

>>> bench/rfr_checker.sv
`timescale 1ns / 1ps
// Checker for the radio frame receiver: watches the byte, status and register channels,
// predicts each status word from the received bytes and compares field by field.
// Depends on rfr_pkg.
module rfr_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output logic        hunting
);
  import rfr_pkg::*;

  logic [CFG_W-1:0] cmd_len;
  logic [CFG_W-1:0] wp_off;
  phase_t           rx_phase;
  logic [7:0]       len_low;
  logic             len_second;
  logic [LEN_W-1:0] frame_len;
  int               stored;
  logic [SUM_W-1:0] byte_sum;
  logic [7:0]       frame_mem [BUFFER_BYTES];
  result_t          reports_due [$];
  result_t          want;

  function void store_byte(input logic [7:0] b);
    if (stored < BUFFER_BYTES) frame_mem[stored] = b;
    stored++;
    byte_sum = byte_sum + SUM_W'(b);
  endfunction

  function void close_frame();
    logic [7:0]       lo;
    logic [7:0]       hi;
    logic [SUM_W-1:0] sum;
    result_t          r;
    rx_phase = PH_HUNT1;
    r.frame_length = frame_len;
    if (frame_len == LEN_W'(cmd_len)) begin
      lo = frame_mem[frame_len - 2];
      hi = frame_mem[frame_len - 1];
      sum = byte_sum - SUM_W'(lo) - SUM_W'(hi);
      r.status = (sum == {hi, lo}) ? ST_CMD_OK : ST_CMD_BAD;
      r.waypoint_count = '0;
    end else begin
      r.status = ST_WAYPOINT;
      r.waypoint_count = WPC_W'((int'(frame_len) - int'(wp_off)) / WAYPOINT_BYTES);
    end
    reports_due.push_back(r);
  endfunction

  function void take_byte(input logic [7:0] b);
    result_t r;
    case (rx_phase)
      PH_HUNT2: begin
        if (b == HDR_SECOND) begin
          store_byte(b);
          len_second = 1'b0;
          rx_phase = PH_LEN;
        end else begin
          byte_sum = '0;
          stored = 0;
          rx_phase = PH_HUNT1;
        end
      end
      PH_LEN: begin
        store_byte(b);
        if (!len_second) begin
          len_low = b;
          len_second = 1'b1;
        end else begin
          len_second = 1'b0;
          frame_len = {b, len_low};
          if (frame_len < MIN_FRAME_LEN || frame_len > MAX_FRAME_LEN ||
              (frame_len != LEN_W'(cmd_len) && frame_len < LEN_W'(wp_off))) begin
            rx_phase = PH_HUNT1;
            r.status = ST_REJECT;
            r.frame_length = frame_len;
            r.waypoint_count = '0;
            reports_due.push_back(r);
          end else begin
            rx_phase = PH_DATA;
            if (stored >= int'(frame_len)) close_frame();
          end
        end
      end
      PH_DATA: begin
        store_byte(b);
        if (stored >= int'(frame_len)) close_frame();
      end
      default: begin
        if (b == HDR_FIRST) begin
          stored = 0;
          byte_sum = '0;
          store_byte(b);
          rx_phase = PH_HUNT2;
        end
      end
    endcase
  endfunction

  function void check_field(input string what, input logic [31:0] exp_v,
                            input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_len = CMD_LENGTH_RESET;
      wp_off = WP_OFFSET_RESET;
      rx_phase = PH_HUNT1;
      len_low = '0;
      len_second = 1'b0;
      frame_len = '0;
      stored = 0;
      byte_sum = '0;
      reports_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CMD_LENGTH) cmd_len = cfg_data;
        else wp_off = cfg_data;
      end
      if (in_tvalid && in_tready) take_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (reports_due.size() == 0) begin
          $display("%0t: unexpected status word, expected none, actual tuser %0h tdata %0h",
                   $time, out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          check_field("status", 32'(want.status), 32'(out_tuser));
          check_field("frame_length", 32'(want.frame_length), 32'(out_tdata[15:0]));
          check_field("waypoint_count", 32'(want.waypoint_count), 32'(out_tdata[25:16]));
          check_field("tdata padding", 32'd0, 32'(out_tdata[31:26]));
        end
      end
    end
    pending = reports_due.size();
    hunting = (rx_phase == PH_HUNT1);
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Top of the radio frame receiver bench: clock, reset, byte and register stimulus,
// random back-pressure, watchdog and verdict. Depends on rfr_pkg, rfr_checker and the RTL.
module tb;
  import rfr_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;

  typedef enum {FILL_RANDOM, FILL_GOOD_SUM, FILL_BAD_SUM} fill_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [9:0]  cfg_data;
  int          fail_count;
  int          pending;
  logic        hunting;

  int cur_cmd;
  int cur_wp;
  int bytes_sent;
  int idle_cycles;
  int stall_left;
  bit sender_steady;
  bit ready_steady;

  radio_frame_receiver_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rfr_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .hunting(hunting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    ready_steady = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 49) == 0) ready_steady = ~ready_steady;
        if (!ready_steady && $urandom_range(0, 5) == 0) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                   : $urandom_range(1, 3);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL radio_frame_receiver_unit");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (sender_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // The body is only sent when the receiver will take the length; otherwise the
  // frame stops after the length bytes.
  task automatic send_frame(input logic [15:0] flen, input fill_t fill);
    logic [7:0]  frame_q [$];
    logic [15:0] sum;
    int          body;
    int          pos;
    int          n;
    body = 0;
    if (flen >= 4 && flen <= BUFFER_BYTES && (int'(flen) == cur_cmd || int'(flen) >= cur_wp))
      body = int'(flen) - 4;
    frame_q.push_back(HDR_FIRST);
    frame_q.push_back(HDR_SECOND);
    frame_q.push_back(flen[7:0]);
    frame_q.push_back(flen[15:8]);
    repeat (body) frame_q.push_back(8'($urandom));
    n = frame_q.size();
    if (fill != FILL_RANDOM && n >= 6) begin
      sum = '0;
      for (int i = 0; i < n - 2; i++) sum += 16'(frame_q[i]);
      frame_q[n - 2] = sum[7:0];
      frame_q[n - 1] = sum[15:8];
      if (fill == FILL_BAD_SUM) begin
        pos = $urandom_range(4, n - 1);
        frame_q[pos] = frame_q[pos] ^ 8'(1 << $urandom_range(0, 7));
      end
    end
    if ($urandom_range(0, 7) == 0) sender_steady = ~sender_steady;
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  task automatic random_frame();
    int    r;
    int    flen;
    fill_t fill;
    r = $urandom_range(0, 99);
    if (r < 40 && (cur_cmd <= 100 || $urandom_range(0, 9) == 0)) begin
      r = $urandom_range(0, 99);
      fill = (r < 60) ? FILL_GOOD_SUM : (r < 85) ? FILL_BAD_SUM : FILL_RANDOM;
      send_frame(16'(cur_cmd), fill);
    end else if (r < 75 && (cur_wp <= 100 || $urandom_range(0, 9) == 0)) begin
      flen = cur_wp + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 512)
                                                   : $urandom_range(0, 48));
      if (flen > BUFFER_BYTES) flen = BUFFER_BYTES;
      send_frame(16'(flen), FILL_RANDOM);
    end else if (r < 88) begin
      case ($urandom_range(0, 4))
        0: flen = $urandom_range(0, 3);
        1: flen = $urandom_range(BUFFER_BYTES + 1, 700);
        2: flen = 16'hFFFF;
        3: flen = $urandom_range(0, 65535);
        default: flen = (cur_wp > 4) ? $urandom_range(4, cur_wp - 1) : 2;
      endcase
      send_frame(16'(flen), FILL_RANDOM);
    end else begin
      repeat ($urandom_range(1, 6))
        send_byte(($urandom_range(0, 2) == 0) ? HDR_FIRST : 8'($urandom));
    end
  endtask

  task automatic send_traffic(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) random_frame();
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Close any open frame with filler bytes, then wait until every status word is out.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (!hunting) begin
      send_byte(8'h00);
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 10'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_CMD_LENGTH) cur_cmd = value;
    else cur_wp = value;
  endtask

  task automatic set_config(input int cmd_value, input int wp_value);
    settle();
    write_reg(REG_CMD_LENGTH, cmd_value);
    write_reg(REG_WP_OFFSET, wp_value);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_CMD_LENGTH;
    cfg_data = '0;
    cur_cmd = int'(CMD_LENGTH_RESET);
    cur_wp = int'(WP_OFFSET_RESET);
    bytes_sent = 0;
    sender_steady = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(16'(cur_cmd), FILL_GOOD_SUM);
    send_frame(16'(cur_cmd), FILL_BAD_SUM);
    send_frame(16'(cur_wp), FILL_RANDOM);
    send_frame(16'(cur_wp + 3 * WAYPOINT_BYTES + 5), FILL_RANDOM);
    send_frame(16'd0, FILL_RANDOM);
    send_frame(16'd3, FILL_RANDOM);
    send_frame(16'(BUFFER_BYTES + 1), FILL_RANDOM);
    send_frame(16'hFFFF, FILL_RANDOM);
    send_frame(16'd10, FILL_RANDOM);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_FIRST);
    send_byte(HDR_FIRST);
    send_byte(HDR_SECOND);
    send_frame(16'(cur_wp), FILL_RANDOM);
    send_traffic(30);

    set_config(4, 4);
    send_frame(16'd4, FILL_RANDOM);
    send_frame(16'd5, FILL_RANDOM);
    send_traffic(20);

    set_config(260, 4);
    send_frame(16'd260, FILL_GOOD_SUM);
    send_frame(16'd4, FILL_RANDOM);

    set_config(20, BUFFER_BYTES);
    send_frame(16'd20, FILL_GOOD_SUM);
    send_frame(16'd100, FILL_RANDOM);
    send_traffic(15);

    set_config(30, 8);
    send_traffic(25);
    drain_results();
    send_traffic(20);

    set_config(int'(CMD_LENGTH_RESET), int'(WP_OFFSET_RESET));
    send_traffic(15);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS radio_frame_receiver_unit");
    end else begin
      $display("FAIL radio_frame_receiver_unit");
    end
    $finish;
  end

endmodule
